// ----- sv/gsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register codes, state and command types for the 1D Poisson
// Gauss-Seidel solver. No dependencies.
package gsp_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;

	localparam int PC_W    = 11;
	localparam int ITER_W  = 32;
	localparam int STEP_W  = 48;
	localparam int TOL_W   = 32;
	localparam int SRC_W   = 32;
	localparam int U_W     = 40;
	localparam int RES_W   = 64;
	localparam int CFG_W   = 48;
	localparam int CFG_I_W = 2;
	localparam int SC_W    = 42;
	localparam int E_W     = 44;
	localparam int MUL_W   = 32;

	localparam logic [PC_W-1:0]   POINT_COUNT_RST = PC_W'(1024);
	localparam logic [ITER_W-1:0] MAX_ITER_RST    = '0;
	localparam logic [STEP_W-1:0] STEP_SQ_RST     = STEP_W'(267911935);
	localparam logic [TOL_W-1:0]  TOL_RST         = TOL_W'(429497);

	localparam logic signed [E_W-1:0] U_MAX = E_W'(64'sd549755813887);
	localparam logic signed [E_W-1:0] U_MIN = E_W'(-64'sd549755813888);

	typedef enum logic [CFG_I_W-1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_MAX_ITER    = 2'd1,
		REG_STEP_SQ     = 2'd2,
		REG_TOL         = 2'd3
	} gsp_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLEAR, ST_PREP, ST_PREP_LATCH, ST_READ, ST_MUL_HI, ST_MUL_LO,
		ST_SCALE, ST_UPDATE, ST_SQ_HH, ST_SQ_HL, ST_SQ_LL, ST_ACCUM, ST_LIM_T,
		ST_LIM_00, ST_LIM_01, ST_LIM_10, ST_LIM_11, ST_TEST, ST_FINISH
	} gsp_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_CLEAR, OP_PREP, OP_PREP_LATCH, OP_READ, OP_MUL_HI,
		OP_MUL_LO, OP_SCALE, OP_UPDATE, OP_SQ_HH, OP_SQ_HL, OP_SQ_LL, OP_ACCUM,
		OP_LIM_T, OP_LIM_00, OP_LIM_01, OP_LIM_10, OP_LIM_11, OP_FINISH
	} gsp_op_t;

	typedef struct packed {
		gsp_op_t op;
	} gsp_cmd_t;

	typedef struct packed {
		logic solve_now;
		logic last;
		logic first_pass;
		logic stop;
	} gsp_status_t;

endpackage

// ----- sv/gauss_seidel_poisson_1d_solver.sv -----
`timescale 1ns / 1ps
// Top level of the 1D Poisson Gauss-Seidel solver: joins controller and datapath.
// Depends on gsp_pkg, gsp_ctrl and gsp_dp.
//
//   Channel   Handshake              Payload
//   -------   --------------------   -----------------------------------------
//   input     start & !busy          source_value
//   result    done (one cycle)       iterations_done, final_residue_sq,
//                                    initial_residue_sq, converged
//   config    cfg_write              cfg_index, cfg_data
//
// Source items load one per cycle while busy is low. The item that completes
// the point count starts a solve: a clearing pass over the solution RAM, then
// sweeps that read, scale, update, square and accumulate one point at a time
// through the shared multiplier, the stop limit after the first sweep, and a
// stop test after each sweep. The finish state registers the result and done.
// Reset clears control state and restores register defaults. The receiver
// cannot stall; done is a one-cycle strobe.
module gauss_seidel_poisson_1d_solver import gsp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [SRC_W-1:0] source_value,
	output logic                    done,
	output logic [ITER_W-1:0]       iterations_done,
	output logic [RES_W-1:0]        final_residue_sq,
	output logic [RES_W-1:0]        initial_residue_sq,
	output logic                    converged,
	input  logic                    cfg_write,
	input  logic [CFG_I_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);
	// The controller only sees status flags; every value lives in the datapath.
	gsp_cmd_t    cmd;
	gsp_status_t status;

	gsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	gsp_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.source_value       (source_value),
		.cmd                (cmd),
		.status             (status),
		.done               (done),
		.iterations_done    (iterations_done),
		.final_residue_sq   (final_residue_sq),
		.initial_residue_sq (initial_residue_sq),
		.converged          (converged)
	);
endmodule

// ----- sv/gsp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/gsp_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the solver: sequences load, clear, sweep passes,
// limit computation and the stop test. Depends on gsp_pkg.
module gsp_ctrl import gsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  gsp_status_t status,
	output gsp_cmd_t    cmd,
	output logic        busy
);
	gsp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (start && status.solve_now) state_d = ST_CLEAR;
			ST_CLEAR:      if (status.last) state_d = ST_PREP;
			ST_PREP:       state_d = ST_PREP_LATCH;
			ST_PREP_LATCH: state_d = ST_READ;
			ST_READ:       state_d = ST_MUL_HI;
			ST_MUL_HI:     state_d = ST_MUL_LO;
			ST_MUL_LO:     state_d = ST_SCALE;
			ST_SCALE:      state_d = ST_UPDATE;
			ST_UPDATE:     state_d = ST_SQ_HH;
			ST_SQ_HH:      state_d = ST_SQ_HL;
			ST_SQ_HL:      state_d = ST_SQ_LL;
			ST_SQ_LL:      state_d = ST_ACCUM;
			ST_ACCUM: begin
				if (!status.last) state_d = ST_READ;
				else if (status.first_pass) state_d = ST_LIM_T;
				else state_d = ST_TEST;
			end
			ST_LIM_T:      state_d = ST_LIM_00;
			ST_LIM_00:     state_d = ST_LIM_01;
			ST_LIM_01:     state_d = ST_LIM_10;
			ST_LIM_10:     state_d = ST_LIM_11;
			ST_LIM_11:     state_d = ST_TEST;
			ST_TEST:       state_d = status.stop ? ST_FINISH : ST_PREP;
			ST_FINISH:     state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		busy   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) cmd.op = OP_LOAD;
			end
			ST_CLEAR:      cmd.op = OP_CLEAR;
			ST_PREP:       cmd.op = OP_PREP;
			ST_PREP_LATCH: cmd.op = OP_PREP_LATCH;
			ST_READ:       cmd.op = OP_READ;
			ST_MUL_HI:     cmd.op = OP_MUL_HI;
			ST_MUL_LO:     cmd.op = OP_MUL_LO;
			ST_SCALE:      cmd.op = OP_SCALE;
			ST_UPDATE:     cmd.op = OP_UPDATE;
			ST_SQ_HH:      cmd.op = OP_SQ_HH;
			ST_SQ_HL:      cmd.op = OP_SQ_HL;
			ST_SQ_LL:      cmd.op = OP_SQ_LL;
			ST_ACCUM:      cmd.op = OP_ACCUM;
			ST_LIM_T:      cmd.op = OP_LIM_T;
			ST_LIM_00:     cmd.op = OP_LIM_00;
			ST_LIM_01:     cmd.op = OP_LIM_01;
			ST_LIM_10:     cmd.op = OP_LIM_10;
			ST_LIM_11:     cmd.op = OP_LIM_11;
			ST_TEST:       cmd.op = OP_NONE;
			ST_FINISH:     cmd.op = OP_FINISH;
			default:       cmd.op = OP_NONE;
		endcase
	end
endmodule

// ----- sv/gsp_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the solver: configuration registers, source and solution RAMs,
// the shared 32x32 multiplier, residual accumulation and result registers.
// Depends on gsp_pkg and gsp_ram.
module gsp_dp import gsp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_I_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic signed [SRC_W-1:0] source_value,
	input  gsp_cmd_t                cmd,
	output gsp_status_t             status,
	output logic                    done,
	output logic [ITER_W-1:0]       iterations_done,
	output logic [RES_W-1:0]        final_residue_sq,
	output logic [RES_W-1:0]        initial_residue_sq,
	output logic                    converged
);
	logic [PC_W-1:0]   point_count_q;
	logic [ITER_W-1:0] max_iter_q;
	logic [STEP_W-1:0] step_q;
	logic [TOL_W-1:0]  tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RST;
			max_iter_q    <= MAX_ITER_RST;
			step_q        <= STEP_SQ_RST;
			tol_q         <= TOL_RST;
		end else if (cfg_write) begin
			case (gsp_reg_t'(cfg_index))
				REG_POINT_COUNT: point_count_q <= cfg_data[PC_W-1:0];
				REG_MAX_ITER:    max_iter_q    <= cfg_data[ITER_W-1:0];
				REG_STEP_SQ:     step_q        <= cfg_data[STEP_W-1:0];
				REG_TOL:         tol_q         <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective point count: zero counts as one, large values clip.
	logic [CNT_W-1:0] n_eff;
	always_comb begin
		if (point_count_q == '0) n_eff = CNT_W'(1);
		else if (32'(point_count_q) > MAX_POINTS) n_eff = CNT_W'(MAX_POINTS);
		else n_eff = CNT_W'(point_count_q);
	end

	logic [CNT_W-1:0]  load_cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [ADDR_W-1:0] idx_q;
	logic              first_q;
	logic              changed_q;
	logic [ITER_W-1:0] sweeps_q;
	logic              done_q;

	logic [SRC_W-1:0]  src_rd;
	logic [U_W-1:0]    sol_rd;
	logic              sol_we;
	logic [U_W-1:0]    sol_wdata;
	logic [ADDR_W-1:0] sol_raddr;

	logic last;
	assign last = ({1'b0, idx_q} == (n_q - CNT_W'(1)));

	gsp_ram #(.WIDTH(SRC_W), .DEPTH(MAX_POINTS)) u_src_ram (
		.clk   (clk),
		.we    (cmd.op == OP_LOAD),
		.waddr (load_cnt_q[ADDR_W-1:0]),
		.wdata (source_value),
		.raddr (idx_q),
		.rdata (src_rd)
	);

	assign sol_raddr = (cmd.op == OP_PREP) ? '0 : idx_q + ADDR_W'(1);

	gsp_ram #(.WIDTH(U_W), .DEPTH(MAX_POINTS)) u_sol_ram (
		.clk   (clk),
		.we    (sol_we),
		.waddr (idx_q),
		.wdata (sol_wdata),
		.raddr (sol_raddr),
		.rdata (sol_rd)
	);

	// Window registers and arithmetic state.
	logic signed [U_W-1:0]  lo_q, ln_q, c_q, ro_q, nv_q;
	logic [MUL_W-1:0]       mag_q;
	logic                   neg_q;
	logic [2*MUL_W-1:0]     p_hi_q, p_lo_q;
	logic signed [SC_W-1:0] s_q;
	logic [U_W-1:0]         m_q;
	logic                   big_q;
	logic [RES_W-1:0]       sq_q, acc_q, res_q, first_res_q, tsq_q;
	logic [2*RES_W-1:0]     lim_q;

	// Shared multiplier.
	logic [MUL_W-1:0]   mul_a, mul_b, mag_in;
	logic [2*MUL_W-1:0] mul_p;
	assign mag_in = src_rd[SRC_W-1] ? (~src_rd + MUL_W'(1)) : src_rd;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_HI: begin mul_a = mag_in; mul_b = MUL_W'(step_q[STEP_W-1:24]); end
			OP_MUL_LO: begin mul_a = mag_q; mul_b = MUL_W'(step_q[23:0]); end
			OP_SQ_HH:  begin mul_a = MUL_W'(m_q[39:20]); mul_b = MUL_W'(m_q[39:20]); end
			OP_SQ_HL:  begin mul_a = MUL_W'(m_q[39:20]); mul_b = MUL_W'(m_q[19:0]); end
			OP_SQ_LL:  begin mul_a = MUL_W'(m_q[19:0]); mul_b = MUL_W'(m_q[19:0]); end
			OP_LIM_T:  begin mul_a = tol_q; mul_b = tol_q; end
			OP_LIM_00: begin mul_a = tsq_q[31:0]; mul_b = first_res_q[31:0]; end
			OP_LIM_01: begin mul_a = tsq_q[31:0]; mul_b = first_res_q[63:32]; end
			OP_LIM_10: begin mul_a = tsq_q[63:32]; mul_b = first_res_q[31:0]; end
			OP_LIM_11: begin mul_a = tsq_q[63:32]; mul_b = first_res_q[63:32]; end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Scaled source, rounded half away from zero to Q.24.
	logic [2*MUL_W-1:0] psum, prnd;
	logic [U_W-1:0]     r_mag;
	assign psum  = p_hi_q + {24'b0, p_lo_q[63:24]};
	assign prnd  = psum + 64'd32768;
	assign r_mag = prnd[55:16];

	// Residual term and Gauss-Seidel update.
	logic signed [E_W-1:0] e, gsum, half, nv_ext;
	logic [E_W-1:0]        m;
	assign e = (E_W'(c_q) <<< 1) - E_W'(lo_q) - E_W'(ro_q) - E_W'(s_q);
	assign gsum = E_W'(ln_q) + E_W'(ro_q) + E_W'(s_q);
	assign half = gsum >>> 1;
	assign m = e[E_W-1] ? E_W'(-e) : E_W'(e);
	always_comb begin
		if (half > U_MAX) nv_ext = U_MAX;
		else if (half < U_MIN) nv_ext = U_MIN;
		else nv_ext = half;
	end

	assign sol_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_UPDATE);
	assign sol_wdata = (cmd.op == OP_UPDATE) ? nv_ext[U_W-1:0] : '0;

	// Saturating residual accumulation.
	logic [RES_W-1:0] term, acc_new;
	logic [RES_W:0]   acc_sum;
	assign term    = big_q ? '1 : sq_q;
	assign acc_sum = {1'b0, acc_q} + {1'b0, term};
	assign acc_new = acc_sum[RES_W] ? '1 : acc_sum[RES_W-1:0];

	// Stop test.
	logic conv_hit, stop;
	assign conv_hit = (res_q <= lim_q[2*RES_W-1:RES_W]);
	always_comb begin
		if (conv_hit) stop = 1'b1;
		else if (max_iter_q != '0) stop = (sweeps_q >= max_iter_q);
		else stop = !changed_q || (sweeps_q == '1);
	end

	assign status.solve_now  = ((load_cnt_q + CNT_W'(1)) >= n_eff);
	assign status.last       = last;
	assign status.first_pass = first_q;
	assign status.stop       = stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			n_q        <= CNT_W'(1);
			idx_q      <= '0;
			first_q    <= 1'b0;
			changed_q  <= 1'b0;
			sweeps_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_FINISH);
			case (cmd.op)
				OP_LOAD: begin
					if (status.solve_now) begin
						load_cnt_q <= '0;
						n_q        <= n_eff;
						idx_q      <= '0;
						first_q    <= 1'b1;
						sweeps_q   <= '0;
					end else begin
						load_cnt_q <= load_cnt_q + CNT_W'(1);
					end
				end
				OP_CLEAR: idx_q <= idx_q + ADDR_W'(1);
				OP_PREP: begin
					idx_q     <= '0;
					changed_q <= 1'b0;
				end
				OP_UPDATE: begin
					if (nv_ext[U_W-1:0] != c_q) changed_q <= 1'b1;
				end
				OP_ACCUM: begin
					idx_q <= idx_q + ADDR_W'(1);
					if (last) begin
						sweeps_q <= sweeps_q + ITER_W'(1);
						first_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PREP: begin
				lo_q  <= '0;
				ln_q  <= '0;
				acc_q <= '0;
			end
			OP_PREP_LATCH: c_q <= sol_rd;
			OP_MUL_HI: begin
				mag_q  <= mag_in;
				neg_q  <= src_rd[SRC_W-1];
				ro_q   <= last ? '0 : sol_rd;
				p_hi_q <= mul_p;
			end
			OP_MUL_LO: p_lo_q <= mul_p;
			OP_SCALE:  s_q <= neg_q ? -$signed({2'b0, r_mag}) : $signed({2'b0, r_mag});
			OP_UPDATE: begin
				nv_q  <= nv_ext[U_W-1:0];
				m_q   <= m[U_W-1:0];
				big_q <= |m[E_W-1:U_W];
			end
			OP_SQ_HH: sq_q <= {mul_p[39:0], 24'b0};
			OP_SQ_HL: sq_q <= sq_q + {19'b0, mul_p[39:0], 5'b0};
			OP_SQ_LL: sq_q <= sq_q + {16'b0, mul_p[63:16]};
			OP_ACCUM: begin
				acc_q <= acc_new;
				lo_q  <= c_q;
				ln_q  <= nv_q;
				c_q   <= ro_q;
				if (last) begin
					res_q <= acc_new;
					if (first_q) first_res_q <= acc_new;
				end
			end
			OP_LIM_T:  tsq_q <= mul_p;
			OP_LIM_00: lim_q <= {64'b0, mul_p};
			OP_LIM_01: lim_q <= lim_q + {32'b0, mul_p, 32'b0};
			OP_LIM_10: lim_q <= lim_q + {32'b0, mul_p, 32'b0};
			OP_LIM_11: lim_q <= lim_q + {mul_p, 64'b0};
			OP_FINISH: begin
				iterations_done    <= sweeps_q;
				final_residue_sq   <= res_q;
				initial_residue_sq <= first_res_q;
				converged          <= conv_hit;
			end
			default: ;
		endcase
	end

	assign done = done_q;
endmodule

// ----- sv/gsp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the solver top level, bound to it below.
// Depends on gsp_pkg.
module gsp_checker import gsp_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    busy,
	input logic                    done,
	input logic [ITER_W-1:0]       iterations_done
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("solve ended without a result");

	a_one_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> iterations_done != '0) else $error("result with no sweep");
endmodule

bind gauss_seidel_poisson_1d_solver gsp_checker u_gsp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.busy            (busy),
	.done            (done),
	.iterations_done (iterations_done)
);
